// ===== rtl/ptt_pkg.sv =====
// Shared types, constants and a helper function for the PID controller with twiddle tuning.
package ptt_pkg;

    localparam int ERROR_BITS      = 16;
    localparam int WINDOW_BITS_DEF = 10;
    localparam int WINDOW_REG_W    = 10;
    localparam int WINDOW_RESET    = 100;
    localparam int GAIN_W          = 32;
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_INDEX_W     = 3;
    localparam int NUM_GAINS       = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_KP     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KI     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KD     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TUNE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW = 3'd4;

    // ceil(2^34 / 5): exact quotient by 5 for any 32-bit dividend after >> 34
    localparam logic [31:0] RECIP_5 = 32'hCCCC_CCCD;

    typedef logic signed [GAIN_W-1:0] t_gain;

    typedef enum logic [1:0] {
        PH_BASE   = 2'd0,
        PH_ADD    = 2'd1,
        PH_SUB    = 2'd2,
        PH_COMMIT = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        SC_TENTH         = 2'd0,
        SC_NINE_TENTHS   = 2'd1,
        SC_ELEVEN_TENTHS = 2'd2
    } t_scale_op;

    typedef struct packed {
        logic                         command;
        logic signed [ERROR_BITS-1:0] track_error;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               reset_request;
        logic [1:0]         tuning_phase;
    } t_out_item;

    typedef struct packed {
        logic      valid;
        t_scale_op op;
        t_gain     x;
    } t_scale_req;

    typedef struct packed {
        logic signed [ERROR_BITS-1:0] p_term;
        logic signed [31:0]           i_term;
        logic signed [31:0]           d_term;
        t_gain                        kp;
        t_gain                        ki;
        t_gain                        kd;
        logic                         reset_request;
        t_phase                       phase;
    } t_terms;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [65:0] hi_lim;
        logic signed [65:0] lo_lim;
        hi_lim = 66'sd2147483647;
        lo_lim = -66'sd2147483648;
        if (x > hi_lim) begin
            return 32'sh7FFF_FFFF;
        end else if (x < lo_lim) begin
            return 32'sh8000_0000;
        end else begin
            return x[31:0];
        end
    endfunction

endpackage

// ===== rtl/ptt_scale.sv =====
// Step scaler lane: round(x * k / 10) half away from zero for k of 1, 9 or 11, saturated.
module ptt_scale (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ptt_pkg::t_scale_req i_req,
    output logic                o_wr_valid,
    output ptt_pkg::t_gain      o_step
);

    logic        a_neg;
    logic [31:0] a_mag;
    logic [32:0] a_biased;
    logic [31:0] a_half;
    logic [63:0] b_prod;

    logic                 r1_valid;
    logic                 r1_neg;
    ptt_pkg::t_scale_op   r1_op;
    logic [31:0]          r1_mag;
    logic [31:0]          r1_half;

    logic                 r2_valid;
    logic                 r2_neg;
    ptt_pkg::t_scale_op   r2_op;
    logic [31:0]          r2_mag;
    logic [29:0]          r2_q;

    logic [32:0]          c_mag;
    logic signed [65:0]   c_signed;

    // x*11/10 = a + (a+5)/10 and x*9/10 = a - (a+4)/10; /10 taken as (>>1) then /5
    always_comb begin
        a_neg    = i_req.x[31];
        a_mag    = a_neg ? (~i_req.x + 32'd1) : i_req.x;
        a_biased = {1'b0, a_mag} + ((i_req.op == ptt_pkg::SC_NINE_TENTHS) ? 33'd4 : 33'd5);
        a_half   = a_biased[32:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_req.valid;
        end
        r1_neg  <= a_neg;
        r1_op   <= i_req.op;
        r1_mag  <= a_mag;
        r1_half <= a_half;
    end

    assign b_prod = r1_half * ptt_pkg::RECIP_5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_neg <= r1_neg;
        r2_op  <= r1_op;
        r2_mag <= r1_mag;
        r2_q   <= b_prod[63:34];
    end

    always_comb begin
        unique case (r2_op)
            ptt_pkg::SC_TENTH:         c_mag = {3'b000, r2_q};
            ptt_pkg::SC_ELEVEN_TENTHS: c_mag = {1'b0, r2_mag} + {3'b000, r2_q};
            ptt_pkg::SC_NINE_TENTHS:   c_mag = {1'b0, r2_mag} - {3'b000, r2_q};
            default:                   c_mag = {3'b000, r2_q};
        endcase
        c_signed = r2_neg ? -$signed({33'd0, c_mag}) : $signed({33'd0, c_mag});
    end

    assign o_wr_valid = r2_valid;
    assign o_step     = ptt_pkg::sat32(c_signed);

endmodule

// ===== rtl/ptt_state.sv =====
// Error terms, gain state and twiddle sequencer; registers the terms for the drive datapath.
module ptt_state #(
    parameter int WINDOW_BITS = ptt_pkg::WINDOW_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_advance,
    input  logic                   i_s1_valid,
    input  ptt_pkg::t_in_item      i_s1_item,
    input  ptt_pkg::t_gain         i_cfg_gain [ptt_pkg::NUM_GAINS],
    input  logic                   i_cfg_enable,
    input  logic [WINDOW_BITS-1:0] i_cfg_window,
    output logic                   o_s2_valid,
    output ptt_pkg::t_terms        o_s2_terms
);

    localparam int EB    = ptt_pkg::ERROR_BITS;
    localparam int CNT_W = WINDOW_BITS + 1;
    localparam int SUM_W = WINDOW_BITS + EB;

    logic signed [EB-1:0]  r_last,     n_last;
    logic signed [31:0]    r_integral, n_integral;
    ptt_pkg::t_gain        r_gain [ptt_pkg::NUM_GAINS];
    ptt_pkg::t_gain        n_gain [ptt_pkg::NUM_GAINS];
    ptt_pkg::t_gain        r_step [ptt_pkg::NUM_GAINS];
    ptt_pkg::t_phase       r_phase,    n_phase;
    logic [CNT_W-1:0]      r_cnt,      n_cnt;
    logic                  r_axis_d,   n_axis_d;
    logic [SUM_W-1:0]      r_wsum,     n_wsum;
    logic [SUM_W-1:0]      r_best,     n_best;
    logic                  r_improved, n_improved;

    logic                  r2_valid;
    ptt_pkg::t_terms       r2_terms,   n_terms;

    ptt_pkg::t_scale_req   n_scale [ptt_pkg::NUM_GAINS];
    logic                  lane_wr [ptt_pkg::NUM_GAINS];
    ptt_pkg::t_gain        lane_step [ptt_pkg::NUM_GAINS];

    logic signed [EB-1:0]  e;
    logic [EB-1:0]         abs_e;
    logic signed [31:0]    d_sat;
    logic signed [31:0]    integ_sat;
    logic [WINDOW_BITS-1:0] win;
    logic [CNT_W-1:0]      win_ext;
    ptt_pkg::t_gain        gain_sel;
    ptt_pkg::t_gain        step_sel;
    ptt_pkg::t_gain        gain_plus;
    ptt_pkg::t_gain        gain_minus;
    logic                  gain_we;
    ptt_pkg::t_gain        gain_wval;
    logic                  req;

    always_comb begin
        e         = i_s1_item.track_error;
        abs_e     = e[EB-1] ? EB'(-e) : EB'(e);
        d_sat     = ptt_pkg::sat32(66'(e) - 66'(r_last));
        integ_sat = ptt_pkg::sat32(66'(r_integral) + 66'(e));
        win       = (i_cfg_window == '0) ? WINDOW_BITS'(1) : i_cfg_window;
        win_ext   = CNT_W'(win);
        gain_sel  = r_axis_d ? r_gain[2] : r_gain[0];
        step_sel  = r_axis_d ? r_step[2] : r_step[0];
        gain_plus = ptt_pkg::sat32(66'(gain_sel) + 66'(step_sel));
        gain_minus = ptt_pkg::sat32(66'(gain_sel) - 66'(step_sel) - 66'(step_sel));
    end

    always_comb begin
        n_last     = r_last;
        n_integral = r_integral;
        n_gain     = r_gain;
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_axis_d   = r_axis_d;
        n_wsum     = r_wsum;
        n_best     = r_best;
        n_improved = r_improved;
        gain_we    = 1'b0;
        gain_wval  = gain_plus;
        req        = 1'b0;
        for (int j = 0; j < ptt_pkg::NUM_GAINS; j++) begin
            n_scale[j].valid = 1'b0;
            n_scale[j].op    = ptt_pkg::SC_TENTH;
            n_scale[j].x     = i_cfg_gain[j];
        end

        if (i_advance && i_s1_valid) begin
            if (i_s1_item.command) begin
                // restart: reload gains, recompute steps, clear the error history and the sequencer
                n_last     = '0;
                n_integral = '0;
                n_gain     = i_cfg_gain;
                n_phase    = ptt_pkg::PH_BASE;
                n_cnt      = '0;
                n_axis_d   = 1'b0;
                n_wsum     = '0;
                n_best     = '0;
                n_improved = 1'b0;
                for (int j = 0; j < ptt_pkg::NUM_GAINS; j++) begin
                    n_scale[j].valid = 1'b1;
                end
            end else begin
                n_last     = e;
                n_integral = integ_sat;
                if (i_cfg_enable) begin
                    unique case (r_phase)
                        ptt_pkg::PH_BASE: begin
                            if (r_cnt < CNT_W'(2)) begin
                                n_cnt = r_cnt + CNT_W'(1);
                            end else if (r_cnt < CNT_W'(2) + win_ext) begin
                                n_wsum = r_wsum + SUM_W'(abs_e);
                                n_cnt  = r_cnt + CNT_W'(1);
                            end else begin
                                n_best  = r_wsum;
                                n_phase = ptt_pkg::PH_ADD;
                                n_cnt   = '0;
                                n_wsum  = '0;
                            end
                        end
                        ptt_pkg::PH_ADD, ptt_pkg::PH_SUB: begin
                            if (r_cnt == '0) begin
                                req   = 1'b1;
                                n_cnt = r_cnt + CNT_W'(1);
                            end else if (r_cnt == CNT_W'(1)) begin
                                gain_we   = 1'b1;
                                gain_wval = (r_phase == ptt_pkg::PH_ADD) ? gain_plus
                                                                         : gain_minus;
                                n_cnt     = r_cnt + CNT_W'(1);
                            end else if (r_cnt <= win_ext + CNT_W'(1)) begin
                                n_wsum = r_wsum + SUM_W'(abs_e);
                                n_cnt  = r_cnt + CNT_W'(1);
                            end else begin
                                if (r_wsum < r_best) begin
                                    n_improved = 1'b1;
                                    n_best     = r_wsum;
                                    n_phase    = ptt_pkg::PH_COMMIT;
                                end else begin
                                    n_improved = 1'b0;
                                    n_phase    = (r_phase == ptt_pkg::PH_ADD) ? ptt_pkg::PH_SUB
                                                                              : ptt_pkg::PH_COMMIT;
                                end
                                n_cnt  = '0;
                                n_wsum = '0;
                            end
                        end
                        ptt_pkg::PH_COMMIT: begin
                            if (!r_improved) begin
                                gain_we   = 1'b1;
                                gain_wval = gain_plus;
                            end
                            for (int j = 0; j < ptt_pkg::NUM_GAINS; j++) begin
                                if ((j == 2 && r_axis_d) || (j == 0 && !r_axis_d)) begin
                                    n_scale[j].valid = 1'b1;
                                    n_scale[j].op    = r_improved ? ptt_pkg::SC_ELEVEN_TENTHS
                                                                  : ptt_pkg::SC_NINE_TENTHS;
                                    n_scale[j].x     = step_sel;
                                end
                            end
                            n_improved = 1'b0;
                            n_axis_d   = !r_axis_d;
                            n_phase    = ptt_pkg::PH_ADD;
                        end
                    endcase
                end
                if (gain_we) begin
                    if (r_axis_d) begin
                        n_gain[2] = gain_wval;
                    end else begin
                        n_gain[0] = gain_wval;
                    end
                end
            end
        end

        // restart zeroes all terms so the drive comes out as 0
        n_terms.p_term        = i_s1_item.command ? '0 : e;
        n_terms.i_term        = i_s1_item.command ? '0 : integ_sat;
        n_terms.d_term        = i_s1_item.command ? '0 : d_sat;
        n_terms.kp            = n_gain[0];
        n_terms.ki            = n_gain[1];
        n_terms.kd            = n_gain[2];
        n_terms.reset_request = req;
        n_terms.phase         = n_phase;
    end

    // Step lanes pass each request through their r1 and r2 registers before r_step takes the result
    for (genvar g = 0; g < ptt_pkg::NUM_GAINS; g++) begin : g_lane
        ptt_scale u_scale (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_req      (n_scale[g]),
            .o_wr_valid (lane_wr[g]),
            .o_step     (lane_step[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last     <= '0;
            r_integral <= '0;
            r_phase    <= ptt_pkg::PH_BASE;
            r_cnt      <= '0;
            r_axis_d   <= 1'b0;
            r_wsum     <= '0;
            r_best     <= '0;
            r_improved <= 1'b0;
            r2_valid   <= 1'b0;
            for (int j = 0; j < ptt_pkg::NUM_GAINS; j++) begin
                r_gain[j] <= '0;
                r_step[j] <= '0;
            end
        end else begin
            r_last     <= n_last;
            r_integral <= n_integral;
            r_phase    <= n_phase;
            r_cnt      <= n_cnt;
            r_axis_d   <= n_axis_d;
            r_wsum     <= n_wsum;
            r_best     <= n_best;
            r_improved <= n_improved;
            r_gain     <= n_gain;
            for (int j = 0; j < ptt_pkg::NUM_GAINS; j++) begin
                if (lane_wr[j]) begin
                    r_step[j] <= lane_step[j];
                end
            end
            if (i_advance) begin
                r2_valid <= i_s1_valid;
            end
        end
        if (i_advance) begin
            r2_terms <= n_terms;
        end
    end

    assign o_s2_valid = r2_valid;
    assign o_s2_terms = r2_terms;

endmodule

// ===== rtl/ptt_drive.sv =====
// Drive datapath: three gain products, their sum, floor by 8 bits and 32-bit saturation.
module ptt_drive (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic               i_s2_valid,
    input  ptt_pkg::t_terms    i_s2_terms,
    output logic               o_valid,
    output ptt_pkg::t_out_item o_item
);

    logic signed [63:0] prod_p;
    logic signed [63:0] prod_i;
    logic signed [63:0] prod_d;
    logic signed [65:0] sum_all;

    logic               r3_valid;
    logic signed [63:0] r3_p;
    logic signed [63:0] r3_i;
    logic signed [63:0] r3_d;
    logic               r3_req;
    ptt_pkg::t_phase    r3_phase;

    logic               r4_valid;
    logic signed [65:0] r4_sum;
    logic               r4_req;
    ptt_pkg::t_phase    r4_phase;

    logic               r_out_valid;
    ptt_pkg::t_out_item r_out;

    always_comb begin
        prod_p  = $signed(i_s2_terms.kp) * $signed(i_s2_terms.p_term);
        prod_i  = $signed(i_s2_terms.ki) * $signed(i_s2_terms.i_term);
        prod_d  = $signed(i_s2_terms.kd) * $signed(i_s2_terms.d_term);
        sum_all = 66'(r3_p) + 66'(r3_i) + 66'(r3_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_advance) begin
            r3_valid    <= i_s2_valid;
            r4_valid    <= r3_valid;
            r_out_valid <= r4_valid;
        end
        if (i_advance) begin
            r3_p     <= prod_p;
            r3_i     <= prod_i;
            r3_d     <= prod_d;
            r3_req   <= i_s2_terms.reset_request;
            r3_phase <= i_s2_terms.phase;

            r4_sum   <= sum_all;
            r4_req   <= r3_req;
            r4_phase <= r3_phase;

            // the products carry 24 fraction bits; drop 8 toward minus infinity
            r_out.drive         <= ptt_pkg::sat32(r4_sum >>> 8);
            r_out.reset_request <= r4_req;
            r_out.tuning_phase  <= r4_phase;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

// ===== rtl/pid_with_twiddle_tuning.sv =====
// Top level of the PID controller with twiddle auto-tuning: handshakes, configuration, stall control.
// One transaction in, one transaction out: each sample command (command 0) takes a signed
// Q8.8 track error and returns drive = Kp*e + Ki*sum(e) + Kd*(e - e_prev) in Q16.16,
// saturated to 32 bits, together with the twiddle reset request and the tuning phase
// after that sample. A restart command (command 1) reloads the gains from the initial
// gain registers, clears the error history and the tuning sequencer, and returns drive 0.
// The block takes one transaction every cycle while the output is not stalled; the
// pipeline runs input register, state update, gain multipliers, sum, saturation,
// and it stalls as a whole while a result waits at the output. The gain steps are
// rescaled by 0.1, 0.9 or 1.1 in a scaler lane per gain that runs beside the
// pipeline; a new step is never needed sooner than two samples later.
// The configuration port is always ready; write it only while no transaction is in flight.
// With tuning enabled the sequencer skips two samples, sums |error| over window_length
// samples as the baseline, then alternates between the P and D gains, trying +step and
// then -2*step, each trial raising reset_request on its first sample.
module pid_with_twiddle_tuning #(
    parameter int WINDOW_BITS = ptt_pkg::WINDOW_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  ptt_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output ptt_pkg::t_out_item                 o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ptt_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [ptt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic                    advance;
    logic                    r_s1_valid;
    ptt_pkg::t_in_item       r_s1_item;

    ptt_pkg::t_gain          r_cfg_gain [ptt_pkg::NUM_GAINS];
    logic                    r_cfg_enable;
    logic [WINDOW_BITS-1:0]  r_cfg_window;

    logic                    s2_valid;
    ptt_pkg::t_terms         s2_terms;

    // Move the whole pipeline whenever the output register is empty or being taken
    assign advance     = !o_out_valid || i_out_ready;
    assign o_in_ready  = advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= i_in_valid;
        end
        if (advance && i_in_valid) begin
            r_s1_item <= i_in_data;
        end
    end

    // Configuration registers; writes beyond the last index are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < ptt_pkg::NUM_GAINS; j++) begin
                r_cfg_gain[j] <= '0;
            end
            r_cfg_enable <= 1'b0;
            r_cfg_window <= WINDOW_BITS'(ptt_pkg::WINDOW_RESET);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ptt_pkg::CFG_KP:     r_cfg_gain[0] <= i_cfg_data;
                ptt_pkg::CFG_KI:     r_cfg_gain[1] <= i_cfg_data;
                ptt_pkg::CFG_KD:     r_cfg_gain[2] <= i_cfg_data;
                ptt_pkg::CFG_TUNE:   r_cfg_enable  <= i_cfg_data[0];
                ptt_pkg::CFG_WINDOW: r_cfg_window  <=
                    WINDOW_BITS'(i_cfg_data[ptt_pkg::WINDOW_REG_W-1:0]);
                default: ;
            endcase
        end
    end

    ptt_state #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_s1_valid   (r_s1_valid),
        .i_s1_item    (r_s1_item),
        .i_cfg_gain   (r_cfg_gain),
        .i_cfg_enable (r_cfg_enable),
        .i_cfg_window (r_cfg_window),
        .o_s2_valid   (s2_valid),
        .o_s2_terms   (s2_terms)
    );

    ptt_drive u_drive (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_s2_valid (s2_valid),
        .i_s2_terms (s2_terms),
        .o_valid    (o_out_valid),
        .o_item     (o_out_data)
    );

endmodule
